[hw/rtl/isua_pkg.sv]
package isua_pkg;

   localparam int DATA_WIDTH_DEF = 64;

   // operation codes
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIV   = 4'd3;
   localparam logic [3:0] OP_FDIV  = 4'd4;
   localparam logic [3:0] OP_REM   = 4'd5;
   localparam logic [3:0] OP_MOD   = 4'd6;
   localparam logic [3:0] OP_AND   = 4'd7;
   localparam logic [3:0] OP_OR    = 4'd8;
   localparam logic [3:0] OP_XOR   = 4'd9;
   localparam logic [3:0] OP_NOT   = 4'd10;
   localparam logic [3:0] OP_SHL   = 4'd11;
   localparam logic [3:0] OP_SHR   = 4'd12;
   localparam logic [3:0] OP_CMP   = 4'd13;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIVZ  = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   // compare outcome codes
   localparam logic [1:0] ORD_EQ   = 2'b00;
   localparam logic [1:0] ORD_GT   = 2'b01;
   localparam logic [1:0] ORD_LT   = 2'b11;
   localparam logic [1:0] ORD_BAD  = 2'b10;

endpackage

[hw/rtl/int64_signed_unsigned_alu_unit.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   type, operand_a, operand_b, a/b_is_signed
// rsp       out        rsp_valid/rsp_ready   result_value, order, status
//
// The result beat passes through DATA_WIDTH + 3 registers: an input register, a
// decode stage, one restoring divider stage per quotient bit, and the output
// register. One beat enters per cycle while the output is not stalled; the
// divider stages set the depth.
// Reset clears every valid bit; payload registers are not reset.
// A stalled output beat freezes the whole pipeline, so req_ready drops with it.
module int64_signed_unsigned_alu_unit
   import isua_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            req_type,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   input  logic                  req_a_is_signed,
   input  logic                  req_b_is_signed,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_result_value,
   output logic [1:0]            rsp_order,
   output logic [1:0]            rsp_status
);

   localparam int W = DATA_WIDTH;
   localparam int H = (W + 1) / 2;   // low half width for the multiplier split
   localparam int L = W - H;         // high half width

   typedef struct packed {
      logic [3:0]     op;
      logic [W-1:0]   a;
      logic [W-1:0]   b;
      logic           an;
      logic           bn;
      logic           ovf;
      logic           bz;
      logic [W-1:0]   sres;
      logic [1:0]     ord;
      logic [W-1:0]   rem;
      logic [W-1:0]   quo;
      logic [W-1:0]   dvd;
      logic [W-1:0]   mb;
      logic [2*H-1:0] pll;
      logic [L-1:0]   plh;
      logic [L-1:0]   phl;
   } stage_type;

   // global advance: the whole pipe moves unless the output beat is stuck
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // input register
   logic         in_vld_ff;
   logic [3:0]   in_op_ff;
   logic [W-1:0] in_a_ff;
   logic [W-1:0] in_b_ff;
   logic         in_sgn_ff;
   logic         in_bsgn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_valid;
      end
      if (en) begin
         in_op_ff   <= req_type;
         in_a_ff    <= req_operand_a;
         in_b_ff    <= req_operand_b;
         in_sgn_ff  <= req_a_is_signed;
         in_bsgn_ff <= req_b_is_signed;
      end
   end

   // decode stage: magnitudes, simple results, partial products
   stage_type      dec_in;
   logic           cmp_an;
   logic           cmp_bn;
   logic [6:0]     sh_amt;
   logic [2*H-1:0] m_ll;
   logic [W-1:0]   m_lh;
   logic [W-1:0]   m_hl;

   always_comb begin
      dec_in     = '0;
      dec_in.op  = in_op_ff;
      dec_in.a   = in_a_ff;
      dec_in.b   = in_b_ff;
      dec_in.an  = in_sgn_ff & in_a_ff[W-1];
      dec_in.bn  = in_sgn_ff & in_b_ff[W-1];
      dec_in.bz  = (in_b_ff == '0);
      dec_in.ovf = in_sgn_ff && (in_a_ff == {1'b1, {(W-1){1'b0}}}) && (in_b_ff == '1);
      dec_in.dvd = dec_in.an ? (~in_a_ff + 1'b1) : in_a_ff;
      dec_in.mb  = dec_in.bn ? (~in_b_ff + 1'b1) : in_b_ff;
      dec_in.rem = '0;
      dec_in.quo = '0;

      m_ll = in_a_ff[H-1:0] * in_b_ff[H-1:0];
      m_lh = in_a_ff[H-1:0] * in_b_ff[W-1:H];
      m_hl = in_a_ff[W-1:H] * in_b_ff[H-1:0];
      dec_in.pll = m_ll;
      dec_in.plh = m_lh[L-1:0];
      dec_in.phl = m_hl[L-1:0];

      sh_amt = {1'b0, in_b_ff[5:0]};
      cmp_an = in_sgn_ff & in_a_ff[W-1];
      cmp_bn = in_bsgn_ff & in_b_ff[W-1];

      case (in_op_ff)
         OP_ADD: dec_in.sres = in_a_ff + in_b_ff;
         OP_SUB: dec_in.sres = in_a_ff - in_b_ff;
         OP_AND: dec_in.sres = in_a_ff & in_b_ff;
         OP_OR:  dec_in.sres = in_a_ff | in_b_ff;
         OP_XOR: dec_in.sres = in_a_ff ^ in_b_ff;
         OP_NOT: dec_in.sres = ~in_a_ff;
         OP_SHL: dec_in.sres = (sh_amt >= 7'(W)) ? '0 : (in_a_ff << sh_amt);
         OP_SHR: dec_in.sres = (sh_amt >= 7'(W)) ? '0 : (in_a_ff >> sh_amt);
         OP_CMP: begin
            // differing sign class decides first, else the raw pattern order holds
            if (cmp_an && !cmp_bn) begin
               dec_in.ord = ORD_LT;
            end else if (cmp_bn && !cmp_an) begin
               dec_in.ord = ORD_GT;
            end else if (in_a_ff < in_b_ff) begin
               dec_in.ord = ORD_LT;
            end else if (in_a_ff > in_b_ff) begin
               dec_in.ord = ORD_GT;
            end else begin
               dec_in.ord = ORD_EQ;
            end
         end
         default: dec_in.sres = '0;
      endcase
   end

   // pipe_ff[0] is the decode register, pipe_ff[k+1] holds divider step k
   stage_type pipe_ff [0:W];
   stage_type pipe_in [0:W];
   logic      vld_ff  [0:W];

   assign pipe_in[0] = dec_in;

   for (genvar k = 0; k < W; k++) begin : g_div
      logic [W:0]   rsh;
      logic [W:0]   diff;
      logic         ge;
      stage_type    cur;
      assign cur = pipe_ff[k];
      always_comb begin
         rsh  = {cur.rem, cur.dvd[W-1]};
         diff = rsh - {1'b0, cur.mb};
         ge   = (rsh >= {1'b0, cur.mb});
         pipe_in[k+1]     = cur;
         pipe_in[k+1].rem = ge ? diff[W-1:0] : rsh[W-1:0];
         pipe_in[k+1].quo = {cur.quo[W-2:0], ge};
         pipe_in[k+1].dvd = {cur.dvd[W-2:0], 1'b0};
         // finish the multiply alongside the first divider step
         if (k == 0 && cur.op == OP_MUL) begin
            pipe_in[k+1].sres = cur.pll[W-1:0] + {cur.plh + cur.phl, {H{1'b0}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= W; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= (i == 0) ? in_vld_ff : vld_ff[(i == 0) ? 0 : i-1];
         end
         if (en) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // final fix-up: sign of quotient and remainder, floor corrections
   stage_type    fin;
   logic [W-1:0] neg_r;
   logic [W-1:0] neg_q;
   logic [W-1:0] mod_adj;
   logic         r_nz;
   logic [W-1:0] res_in;
   logic [1:0]   st_in;

   assign fin = pipe_ff[W];

   always_comb begin
      neg_r   = ~fin.rem + 1'b1;
      neg_q   = ~fin.quo + 1'b1;
      r_nz    = (fin.rem != '0);
      mod_adj = fin.an ? (fin.b - fin.rem) : (fin.rem + fin.b);
      res_in  = fin.sres;
      st_in   = ST_OK;
      case (fin.op)
         OP_DIV, OP_FDIV, OP_REM: begin
            if (fin.bz) begin
               res_in = '0;
               st_in  = ST_DIVZ;
            end else if (fin.ovf) begin
               res_in = '0;
               st_in  = ST_OVF;
            end else if (fin.op == OP_REM) begin
               res_in = fin.an ? neg_r : fin.rem;
            end else if (fin.an != fin.bn) begin
               // floored: -(q+1) is ~q
               res_in = (fin.op == OP_FDIV && r_nz) ? ~fin.quo : neg_q;
            end else begin
               res_in = fin.quo;
            end
         end
         OP_MOD: begin
            if (fin.bz) begin
               res_in = fin.a;
            end else if (fin.an != fin.bn && r_nz) begin
               res_in = mod_adj;
            end else begin
               res_in = fin.an ? neg_r : fin.rem;
            end
         end
         default: res_in = fin.sres;
      endcase
   end

   // output register
   logic         out_vld_ff;
   logic [W-1:0] out_res_ff;
   logic [1:0]   out_ord_ff;
   logic [1:0]   out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[W];
      end
      if (en) begin
         out_res_ff <= res_in;
         out_ord_ff <= fin.ord;
         out_st_ff  <= st_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_result_value = out_res_ff;
   assign rsp_order        = out_ord_ff;
   assign rsp_status       = out_st_ff;

   // an error beat carries a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_value == '0)
      else $error("error beat with nonzero result");

   // a compare outcome never comes with an error status
   a_ord_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_order != ORD_EQ |-> rsp_status == ST_OK)
      else $error("compare outcome with error status");

   // the unused order code never appears
   a_ord_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_order != ORD_BAD)
      else $error("bad order code");

   // an accepted beat lands in the input register
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_vld_ff)
      else $error("accepted beat lost");

endmodule

[verif/tb_int64_signed_unsigned_alu_unit.sv]
`timescale 1ns / 1ps

module tb_int64_signed_unsigned_alu_unit
   import isua_pkg::*;
();

   localparam int W = 64;
   localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = W + 20;
   localparam int RANDOM_BEATS = 550;

   typedef struct packed {
      logic [W-1:0] value;
      logic [1:0]   order;
      logic [1:0]   status;
   } alu_result_type;

   // Expected results of accepted request beats, oldest first.
   class alu_scoreboard;
      alu_result_type pending[$];
      int             errors;

      function logic [W-1:0] negate(logic [W-1:0] v);
         return ~v + 1'b1;
      endfunction

      // Work out the result of one request beat and queue it.
      function void note_request(logic [3:0] op, logic [W-1:0] a, logic [W-1:0] b,
                                 logic a_sgn, logic b_sgn);
         alu_result_type r;
         logic           a_neg, b_neg, bc_neg, ovf;
         logic [W-1:0]   ma, mb, q, rm, t;
         logic [5:0]     sh;
         r = '0;
         r.order = ORD_EQ;
         r.status = ST_OK;
         a_neg = a_sgn && a[W-1];
         b_neg = a_sgn && b[W-1];
         bc_neg = b_sgn && b[W-1];
         ma = a_neg ? negate(a) : a;
         mb = b_neg ? negate(b) : b;
         ovf = a_sgn && a == SIGN_BIT && b == ALL_ONES;
         sh = b[5:0];
         q = '0;
         rm = '0;
         if (mb != 0) begin
            q = ma / mb;
            rm = ma % mb;
         end
         case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = a * b;
            OP_DIV, OP_FDIV, OP_REM: begin
               if (b == 0) r.status = ST_DIVZ;
               else if (ovf) r.status = ST_OVF;
               else if (op == OP_REM) r.value = a_neg ? negate(rm) : rm;
               else if (a_neg != b_neg) begin
                  if (op == OP_FDIV && rm != 0) q = q + 1'b1;
                  r.value = negate(q);
               end else r.value = q;
            end
            OP_MOD: begin
               if (b == 0) r.value = a;
               else begin
                  t = a_neg ? negate(rm) : rm;
                  if (a_neg != b_neg && rm != 0) t = t + b;
                  r.value = t;
               end
            end
            OP_AND: r.value = a & b;
            OP_OR:  r.value = a | b;
            OP_XOR: r.value = a ^ b;
            OP_NOT: r.value = ~a;
            OP_SHL: r.value = (sh >= W) ? '0 : a << sh;
            OP_SHR: r.value = (sh >= W) ? '0 : a >> sh;
            OP_CMP: begin
               if (a_neg && !bc_neg) r.order = ORD_LT;
               else if (bc_neg && !a_neg) r.order = ORD_GT;
               else if (a < b) r.order = ORD_LT;
               else if (a > b) r.order = ORD_GT;
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      // Compare one result beat against the oldest expectation.
      function void check_result(logic [W-1:0] value, logic [1:0] order, logic [1:0] status);
         alu_result_type e;
         if (pending.size() == 0) begin
            $error("result beat with nothing expected: value=%h", value);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) begin
            $error("result_value: expected %h, got %h", e.value, value);
            errors++;
         end
         if (order !== e.order) begin
            $error("order: expected %b, got %b", e.order, order);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [3:0]    req_type;
   logic [W-1:0]  req_operand_a;
   logic [W-1:0]  req_operand_b;
   logic          req_a_is_signed;
   logic          req_b_is_signed;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [W-1:0]  rsp_result_value;
   logic [1:0]    rsp_order;
   logic [1:0]    rsp_status;

   alu_scoreboard sb;
   bit            stim_done;
   int            idle_cycles;

   int64_signed_unsigned_alu_unit #(.DATA_WIDTH(W)) dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Mostly short gaps, now and then a long one, sometimes none at all.
   function int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function logic [W-1:0] negate_small(int v);
      return ~W'(v) + 1'b1;
   endfunction

   // Pick an operand that lands on the interesting corners more often than chance.
   function logic [W-1:0] pick_operand();
      case ($urandom_range(9))
         0: return '0;
         1: return ALL_ONES;
         2: return SIGN_BIT;
         3: return ~SIGN_BIT;
         4: return W'($urandom_range(8));
         5: return negate_small($urandom_range(8));
         6: return {$urandom, $urandom} >> $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Drive one request beat, hold it until accepted, then record it.
   task send_request(logic [3:0] op, logic [W-1:0] a, logic [W-1:0] b, logic as, logic bs);
      req_valid <= 1'b1;
      req_type <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      req_a_is_signed <= as;
      req_b_is_signed <= bs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, a, b, as, bs);
   endtask

   task idle_request(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Stall the result channel at random.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         rsp_ready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(3) == 0) begin
            stall = gap_length();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Check every result beat at the edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_result_value, rsp_order, rsp_status);
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("int64_signed_unsigned_alu_unit test failed");
         $finish;
      end
   end

   initial begin
      logic [3:0] op;
      int         gap;
      sb = new();
      stim_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = OP_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      req_a_is_signed = 1'b0;
      req_b_is_signed = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every opcode, division corners, shifts, compares.
      send_request(OP_ADD, ALL_ONES, 64'd1, 1'b0, 1'b0);
      send_request(OP_SUB, '0, 64'd1, 1'b1, 1'b1);
      send_request(OP_MUL, SIGN_BIT, ALL_ONES, 1'b1, 1'b0);
      send_request(OP_DIV, 64'd7, '0, 1'b1, 1'b0);
      send_request(OP_FDIV, 64'd7, '0, 1'b0, 1'b0);
      send_request(OP_REM, 64'd7, '0, 1'b1, 1'b0);
      send_request(OP_MOD, 64'd7, '0, 1'b1, 1'b0);
      send_request(OP_DIV, SIGN_BIT, ALL_ONES, 1'b1, 1'b0);
      send_request(OP_FDIV, SIGN_BIT, ALL_ONES, 1'b1, 1'b0);
      send_request(OP_REM, SIGN_BIT, ALL_ONES, 1'b1, 1'b0);
      send_request(OP_MOD, SIGN_BIT, ALL_ONES, 1'b1, 1'b0);
      send_request(OP_FDIV, negate_small(7), 64'd2, 1'b1, 1'b0);
      send_request(OP_MOD, negate_small(7), 64'd2, 1'b1, 1'b0);
      send_request(OP_MOD, 64'd7, negate_small(2), 1'b1, 1'b0);
      send_request(OP_DIV, SIGN_BIT, ALL_ONES, 1'b0, 1'b1);
      send_request(OP_AND, ALL_ONES, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, 1'b0);
      send_request(OP_OR, '0, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0, 1'b0);
      send_request(OP_XOR, ALL_ONES, ALL_ONES, 1'b1, 1'b1);
      send_request(OP_NOT, 64'h1234, ALL_ONES, 1'b0, 1'b0);
      send_request(OP_SHL, ALL_ONES, 64'hffff_ff7f, 1'b0, 1'b0);
      send_request(OP_SHR, ALL_ONES, 64'd63, 1'b1, 1'b0);
      send_request(OP_CMP, ALL_ONES, 64'd1, 1'b1, 1'b0);
      send_request(OP_CMP, 64'd1, ALL_ONES, 1'b0, 1'b1);
      send_request(OP_CMP, ALL_ONES, ALL_ONES, 1'b1, 1'b1);
      send_request(4'd14, ALL_ONES, ALL_ONES, 1'b1, 1'b1);
      send_request(4'd15, ALL_ONES, '0, 1'b0, 1'b1);

      // Random part; division ops get extra weight since they hold the corner cases.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         gap = ($urandom_range(2) == 0) ? gap_length() : 0;
         if (gap > 0) idle_request(gap);
         if ($urandom_range(2) == 0) op = 4'($urandom_range(OP_MOD, OP_DIV));
         else op = 4'($urandom_range(15));
         send_request(op, pick_operand(), pick_operand(), 1'($urandom), 1'($urandom));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // End of run: drain expectations, give the pipe time to show strays, report.
   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("int64_signed_unsigned_alu_unit test passed");
      else
         $display("int64_signed_unsigned_alu_unit test failed");
      $finish;
   end

endmodule

[int64_signed_unsigned_alu_unit.f]
hw/rtl/isua_pkg.sv
hw/rtl/int64_signed_unsigned_alu_unit.sv
verif/tb_int64_signed_unsigned_alu_unit.sv
